// ===== rtl/assert_macros.svh =====
// Assertion macros used by the pulse rate detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PRD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Check that a condition leads to a consequence on the next clock edge.
`define PRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/prd_pkg.sv =====
// Types and constants of the pulse rate detector.
package prd_pkg;

	localparam int unsigned WINDOW_DEF    = 100;
	localparam int unsigned AVG_BEATS_DEF = 10;

	localparam int unsigned SAMPLE_W  = 10;
	localparam int unsigned ELAPSED_W = 10;
	localparam int unsigned LEVEL_W   = 16;
	localparam int unsigned TIME_W    = 16;
	localparam int unsigned WEIGHT_W  = 9;
	localparam int unsigned ONE_Q6    = 64;

	localparam logic [LEVEL_W-1:0]  LEVEL_RESET    = 16'd33280;
	localparam logic [TIME_W-1:0]   TIME_MAX       = 16'hFFFF;
	localparam logic [TIME_W-1:0]   LAST_IVL_RESET = 16'd600;
	localparam logic [TIME_W-1:0]   MIN_IVL_RESET  = 16'd300;
	localparam logic [TIME_W-1:0]   MAX_IVL_RESET  = 16'd2500;
	localparam logic [TIME_W-1:0]   MS_PER_MIN     = 16'd60000;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET   = 9'd51;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = 9'd256;

	typedef enum logic [1:0] {
		REG_FILTER_WEIGHT = 2'd0,
		REG_MIN_INTERVAL  = 2'd1,
		REG_MAX_INTERVAL  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILT,
		S_WIN,
		S_CMP,
		S_AVG,
		S_DIV,
		S_OUT
	} prd_state_t;

endpackage

// ===== rtl/prd_div.sv =====
// Unsigned restoring divider, two quotient bits per cycle.
module prd_div #(
	parameter int unsigned W = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int unsigned STEPS = (W + 1) / 2;
	localparam int unsigned DW    = 2 * STEPS;
	localparam int unsigned CNT_W = $clog2(STEPS + 1);

	logic [W-1:0]     rem_q;
	logic [DW-1:0]    quo_q;
	logic [W-1:0]     div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W-1:0]     rem_nx;
	logic [DW-1:0]    quo_nx;

	// Two shift-compare-subtract steps per cycle.
	always_comb begin
		logic [W-1:0]  r;
		logic [DW-1:0] q;
		logic [W:0]    t;
		r = rem_q;
		q = quo_q;
		t = '0;
		for (int i = 0; i < 2; i++) begin
			t = {r, q[DW-1]};
			q = {q[DW-2:0], 1'b0};
			if (t >= {1'b0, div_q}) begin
				t    = t - {1'b0, div_q};
				q[0] = 1'b1;
			end
			r = t[W-1:0];
		end
		rem_nx = r;
		quo_nx = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= DW'(dividend);
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q[W-1:0];

endmodule

// ===== rtl/pulse_rate_detector_top.sv =====
// Pulse rate detector: filters sensor samples, detects beats and reports beats per minute.
// Sequence: an accepted sample passes S_FILT, S_WIN and S_CMP, and S_OUT loads the result;
// after a beat without timeout, S_AVG and the divider for beats per minute come before S_OUT.
// Throughput: one sample at a time; the next is taken the cycle after the result is loaded.
// Reset: arst_n asynchronously clears control and detector state; no clearing pass is needed.
`include "assert_macros.svh"

module pulse_rate_detector_top import prd_pkg::*; #(
	parameter int unsigned WINDOW    = WINDOW_DEF,
	parameter int unsigned AVG_BEATS = AVG_BEATS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Sample stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // sample[9:0], elapsed_ms[19:10], zero pad
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // beat[0], interval_ms[16:1], bpm[32:17], timed_out[33], pad
	output logic [0:0]  m_tuser,   // bpm_valid[0]
	// Register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Window index, ring index and accumulator widths follow from the parameters.
	localparam int unsigned WPOS_W = $clog2(WINDOW);
	localparam int unsigned RPOS_W = $clog2(AVG_BEATS);
	localparam int unsigned WSUM_W = LEVEL_W + $clog2(WINDOW);
	localparam int unsigned CMP_W  = WSUM_W + 1;
	localparam int unsigned ISUM_W = TIME_W + $clog2(AVG_BEATS);
	// Reciprocal of AVG_BEATS, rounded up, exact for every ISUM_W-bit sum.
	localparam int unsigned AVG_SH = ISUM_W + $clog2(AVG_BEATS);
	localparam int unsigned PROD_W = AVG_SH + ISUM_W;
	localparam logic [PROD_W-1:0] AVG_RECIP =
		PROD_W'(((64'd1 << AVG_SH) + 64'(AVG_BEATS - 1)) / 64'(AVG_BEATS));

	// Configuration registers
	logic [WEIGHT_W-1:0] weight_q;
	logic [TIME_W-1:0]   min_ivl_q;
	logic [TIME_W-1:0]   max_ivl_q;

	// Sequencer
	prd_state_t state_q, state_nx;

	// Accepted sample
	logic [SAMPLE_W-1:0]  x_q;
	logic [ELAPSED_W-1:0] dt_q;

	// Detector state
	logic [LEVEL_W-1:0]   level_q;
	logic [WSUM_W-1:0]    win_sum_q;
	logic [WPOS_W-1:0]    win_pos_q;
	logic                 win_full_q;
	logic [TIME_W-1:0]    since_q;
	logic [RPOS_W-1:0]    ring_pos_q;
	logic [ISUM_W-1:0]    isum_q;
	logic                 need_seed_q;
	logic [TIME_W-1:0]    rate_q;
	logic                 rate_ok_q;
	logic [TIME_W-1:0]    last_ivl_q;
	logic [TIME_W-1:0]    seed_q;
	logic [AVG_BEATS-1:0] ring_wr_q;
	logic                 beat_q;
	logic                 tmo_q;

	// Memories with registered read ports
	logic [LEVEL_W-1:0] win_mem [WINDOW];
	logic [LEVEL_W-1:0] win_rd_q;
	logic [TIME_W-1:0]  ring_mem [AVG_BEATS];
	logic [TIME_W-1:0]  ring_rd_q;

	// Output register
	logic               m_tvalid_q;
	logic               o_beat_q;
	logic [TIME_W-1:0]  o_ivl_q;
	logic [TIME_W-1:0]  o_bpm_q;
	logic               o_ok_q;
	logic               o_tmo_q;

	// Datapath
	logic [WEIGHT_W-1:0]  w_sat;
	logic [WEIGHT_W-1:0]  w_inv;
	logic [24:0]          filt_acc;
	logic [LEVEL_W-1:0]   level_nx;
	logic [TIME_W:0]      since_sum;
	logic [TIME_W-1:0]    since_sat;
	logic [LEVEL_W-1:0]   win_old;
	logic [WSUM_W-1:0]    win_sum_nx;
	logic [CMP_W-1:0]     lhs;
	logic [CMP_W-1:0]     rhs;
	logic                 beat_now;
	logic                 tmo_now;
	logic [TIME_W-1:0]    ring_old;
	logic [ISUM_W-1:0]    isum_nx;
	logic [AVG_BEATS-1:0] ring_hot;
	logic [PROD_W-1:0]    avg_prod;
	logic [ISUM_W-1:0]    avg_ivl;

	// Control
	logic              s_fire;
	logic              cfg_wr;
	logic              out_load;
	logic              out_stall;
	logic              div_start;
	logic [ISUM_W-1:0] div_dividend;
	logic [ISUM_W-1:0] div_divisor;
	logic              div_busy;
	logic              div_done;
	logic [ISUM_W-1:0] div_quot;

	assign s_fire = s_tvalid && s_tready;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	// ---------------------------------------------------------------
	// Register port: decode on the word address, ignore byte offsets.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q  <= WEIGHT_RESET;
			min_ivl_q <= MIN_IVL_RESET;
			max_ivl_q <= MAX_IVL_RESET;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_FILTER_WEIGHT: weight_q  <= pwdata[WEIGHT_W-1:0];
				REG_MIN_INTERVAL:  min_ivl_q <= pwdata[TIME_W-1:0];
				REG_MAX_INTERVAL:  max_ivl_q <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_FILTER_WEIGHT: prdata = 32'(weight_q);
			REG_MIN_INTERVAL:  prdata = 32'(min_ivl_q);
			REG_MAX_INTERVAL:  prdata = 32'(max_ivl_q);
			default:           prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Low-pass filter (Q10.6): weight above 1.0 saturates to 1.0.
	// ---------------------------------------------------------------
	assign w_sat     = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
	assign w_inv     = WEIGHT_ONE - w_sat;
	assign filt_acc  = (25'(w_sat) * 25'({x_q, 6'd0})) + (25'(w_inv) * 25'(level_q));
	assign level_nx  = filt_acc[23:8];

	// Time since the last beat saturates at the 16-bit maximum.
	assign since_sum = {1'b0, since_q} + (TIME_W + 1)'(dt_q);
	assign since_sat = since_sum[TIME_W] ? TIME_MAX : since_sum[TIME_W-1:0];

	// ---------------------------------------------------------------
	// Moving window: entries past the write pointer read as zero until
	// the pointer has wrapped once.
	// ---------------------------------------------------------------
	assign win_old    = win_full_q ? win_rd_q : '0;
	assign win_sum_nx = win_sum_q - WSUM_W'(win_old) + WSUM_W'(level_q);

	// Level above average plus one, compared exactly against the scaled sum.
	assign lhs      = CMP_W'(level_q) * CMP_W'(WINDOW);
	assign rhs      = CMP_W'(win_sum_q) + CMP_W'(ONE_Q6 * WINDOW);
	assign beat_now = (lhs > rhs) && (since_q > min_ivl_q);
	assign tmo_now  = since_q > max_ivl_q;

	// ---------------------------------------------------------------
	// Interval ring: a seed value stands in for every entry not yet
	// written since the last restart, so seeding takes no sweep.
	// ---------------------------------------------------------------
	assign ring_hot = AVG_BEATS'(1) << ring_pos_q;
	assign ring_old = ring_wr_q[ring_pos_q] ? ring_rd_q : seed_q;
	assign isum_nx  = need_seed_q ? (ISUM_W'(since_q) * ISUM_W'(AVG_BEATS))
	                              : (isum_q - ISUM_W'(ring_old) + ISUM_W'(since_q));

	// Average interval: multiply the ring sum by the scaled reciprocal.
	assign avg_prod = PROD_W'(isum_q) * AVG_RECIP;
	assign avg_ivl  = avg_prod[AVG_SH +: ISUM_W];

	always_ff @(posedge clk) begin
		win_rd_q <= win_mem[win_pos_q];
		if (state_q == S_WIN) begin
			win_mem[win_pos_q] <= level_q;
		end
	end

	always_ff @(posedge clk) begin
		ring_rd_q <= ring_mem[ring_pos_q];
		if (state_q == S_CMP && beat_now) begin
			ring_mem[ring_pos_q] <= since_q;
		end
	end

	// ---------------------------------------------------------------
	// Sequencer: next state
	// ---------------------------------------------------------------
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: if (s_tvalid) begin
				state_nx = S_FILT;
			end
			S_FILT: state_nx = S_WIN;
			S_WIN:  state_nx = S_CMP;
			S_CMP:  state_nx = (beat_now && !tmo_now) ? S_AVG : S_OUT;
			S_AVG:  state_nx = S_DIV;
			S_DIV:  if (div_done) begin
				state_nx = S_OUT;
			end
			S_OUT:  if (!m_tvalid_q || m_tready) begin
				state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// Sequencer: outputs. The average interval comes from the updated ring
	// sum; the divider turns it into beats per minute.
	always_comb begin
		s_tready     = 1'b0;
		out_load     = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_AVG: begin
				div_start    = 1'b1;
				div_dividend = ISUM_W'(MS_PER_MIN);
				div_divisor  = (avg_ivl == '0) ? ISUM_W'(1) : avg_ivl;
			end
			S_OUT: out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// ---------------------------------------------------------------
	// Detector state update
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s_fire) begin
			x_q  <= s_tdata[SAMPLE_W-1:0];
			dt_q <= s_tdata[SAMPLE_W +: ELAPSED_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= LEVEL_RESET;
			win_sum_q   <= '0;
			win_pos_q   <= '0;
			win_full_q  <= 1'b0;
			since_q     <= '0;
			ring_pos_q  <= '0;
			isum_q      <= '0;
			need_seed_q <= 1'b1;
			rate_q      <= '0;
			rate_ok_q   <= 1'b0;
			last_ivl_q  <= LAST_IVL_RESET;
			seed_q      <= '0;
			ring_wr_q   <= '0;
			beat_q      <= 1'b0;
			tmo_q       <= 1'b0;
		end else begin
			case (state_q)
				S_FILT: begin
					level_q <= level_nx;
					since_q <= since_sat;
				end
				S_WIN: begin
					win_sum_q <= win_sum_nx;
					if (win_pos_q == WPOS_W'(WINDOW - 1)) begin
						win_pos_q  <= '0;
						win_full_q <= 1'b1;
					end else begin
						win_pos_q <= win_pos_q + WPOS_W'(1);
					end
				end
				S_CMP: begin
					beat_q <= beat_now;
					tmo_q  <= tmo_now;
					if (beat_now) begin
						last_ivl_q  <= since_q;
						since_q     <= '0;
						isum_q      <= isum_nx;
						need_seed_q <= 1'b0;
						ring_pos_q  <= (ring_pos_q == RPOS_W'(AVG_BEATS - 1)) ? '0
						               : ring_pos_q + RPOS_W'(1);
						if (need_seed_q) begin
							seed_q    <= since_q;
							ring_wr_q <= ring_hot;
						end else begin
							ring_wr_q <= ring_wr_q | ring_hot;
						end
					end
					// Restart after the beat so it overrides the beat's interval updates.
					if (tmo_now) begin
						since_q     <= '0;
						isum_q      <= '0;
						need_seed_q <= 1'b1;
						rate_q      <= '0;
						rate_ok_q   <= 1'b0;
					end
				end
				S_DIV: if (div_done) begin
					rate_q    <= div_quot[TIME_W-1:0];
					rate_ok_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	prd_div #(
		.W (ISUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// ---------------------------------------------------------------
	// Output register: holds a result while the next sample is taken.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_beat_q <= beat_q;
			o_ivl_q  <= last_ivl_q;
			o_bpm_q  <= rate_q;
			o_ok_q   <= rate_ok_q;
			o_tmo_q  <= tmo_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = {6'd0, o_tmo_q, o_bpm_q, o_ivl_q, o_beat_q};
	assign m_tuser[0] = o_ok_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	assign out_stall = (state_q == S_OUT) && !out_load;

	`PRD_ASSERT(a_rate_cleared, !rate_ok_q |-> (rate_q == '0), "rate nonzero while not valid")
	`PRD_ASSERT(a_seed_sum, need_seed_q |-> (isum_q == '0), "interval sum kept across restart")
	`PRD_ASSERT(a_div_idle, div_start |-> !div_busy, "divider restarted while busy")
	`PRD_ASSERT(a_win_pos, win_pos_q <= WPOS_W'(WINDOW - 1), "window pointer out of range")
	`PRD_ASSERT(a_ring_pos, ring_pos_q <= RPOS_W'(AVG_BEATS - 1), "ring pointer out of range")
	`PRD_ASSERT_NEXT(a_out_stall, out_stall, (state_q == S_OUT) && m_tvalid_q, "result dropped")

endmodule
